### rtl/cscos_pkg.sv
// ----------------------------------------------------------------------------
// cscos_pkg
// Shared types, constants and the arctangent table for the CORDIC sine/cosine
// generator.
// ----------------------------------------------------------------------------
package cscos_pkg;

  localparam int CNT_W          = 5;      // iteration count register width
  localparam int FIELD_W        = 18;     // angle / cosine / sine port width
  localparam int TABLE_SIZE     = 16;
  localparam int TABLE_FRAC     = 30;     // fractional bits of the atan table
  localparam int GAIN_NUM       = 39797;  // K * 2^16
  localparam int GAIN_SHIFT     = 16;
  localparam int DEF_MAX_ITER   = 16;
  localparam int DEF_FRAC_BITS  = 16;

  localparam logic [CNT_W-1:0] ITER_RESET = CNT_W'(16);

  // round(atan(2^-i) * 2^30)
  localparam logic [31:0] ATAN_Q30 [TABLE_SIZE] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768
  };

  // Control word that walks down the cell row beside the data.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

  // Micro-rotation angle of step i, rounded half up to frac fractional bits.
  function automatic logic [31:0] atan_step(input int i, input int frac);
    logic [63:0] a;
    logic [63:0] r;
    a = {32'd0, ATAN_Q30[i]};
    r = (a + (64'd1 << (TABLE_FRAC - frac - 1))) >> (TABLE_FRAC - frac);
    return r[31:0];
  endfunction

endpackage

### rtl/cscos_cell.sv
// ----------------------------------------------------------------------------
// cscos_cell
// One CORDIC micro-rotation stage: rotate by atan(2^-STAGE) or pass through.
// ----------------------------------------------------------------------------
module cscos_cell #(
  parameter int STAGE     = 0,
  parameter int FRAC_BITS = 16,
  parameter int DW        = 19,
  parameter int ZW        = 19
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cscos_pkg::cell_ctrl_t   ctrl_i,
  input  logic signed [DW-1:0]    x_i,
  input  logic signed [DW-1:0]    y_i,
  input  logic signed [ZW-1:0]    z_i,
  output cscos_pkg::cell_ctrl_t   ctrl_o,
  output logic signed [DW-1:0]    x_o,
  output logic signed [DW-1:0]    y_o,
  output logic signed [ZW-1:0]    z_o
);
  import cscos_pkg::*;

  localparam logic [CNT_W-1:0]  STAGE_C = CNT_W'(STAGE);
  localparam logic signed [ZW-1:0] ANGLE = ZW'(atan_step(STAGE, FRAC_BITS));

  cell_ctrl_t           ctrl_q;
  logic signed [DW-1:0] x_d, x_q, y_d, y_q, xs, ys;
  logic signed [ZW-1:0] z_d, z_q;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;

  always_comb begin
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    // rotate only while this stage is inside the requested count
    if (ctrl_i.count > STAGE_C) begin
      if (z_i[ZW-1]) begin
        x_d = x_i + ys;
        y_d = y_i - xs;
        z_d = z_i + ANGLE;
      end else begin
        x_d = x_i - ys;
        y_d = y_i + xs;
        z_d = z_i - ANGLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

### rtl/cscos_gain.sv
// ----------------------------------------------------------------------------
// cscos_gain
// Gain correction: scale x and y by K, floor-shift, saturate to the port width.
// ----------------------------------------------------------------------------
module cscos_gain #(
  parameter int DW = 19
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [DW-1:0]                  x_i,
  input  logic signed [DW-1:0]                  y_i,
  output logic                                  valid_o,
  output logic signed [cscos_pkg::FIELD_W-1:0]  x_o,
  output logic signed [cscos_pkg::FIELD_W-1:0]  y_o
);
  import cscos_pkg::*;

  localparam int PW = DW + GAIN_SHIFT + 1;
  localparam logic signed [GAIN_SHIFT:0] GAIN  = (GAIN_SHIFT+1)'(GAIN_NUM);
  localparam logic signed [PW-1:0] SAT_HI = PW'((1 << (FIELD_W - 1)) - 1);
  localparam logic signed [PW-1:0] SAT_LO = -PW'(1 << (FIELD_W - 1));

  logic                        mul_valid_q, out_valid_q;
  logic signed [PW-1:0]        px_q, py_q, sx, sy;
  logic signed [FIELD_W-1:0]   x_d, y_d, x_q, y_q;

  function automatic logic signed [FIELD_W-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [FIELD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[FIELD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[FIELD_W-1:0];
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

  assign sx  = px_q >>> GAIN_SHIFT;
  assign sy  = py_q >>> GAIN_SHIFT;
  assign x_d = sat(sx);
  assign y_d = sat(sy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= valid_i;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= PW'(x_i) * PW'(GAIN);
    py_q <= PW'(y_i) * PW'(GAIN);
    x_q  <= x_d;
    y_q  <= y_d;
  end

  assign valid_o = out_valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

### rtl/cordic_sine_cosine_top.sv
// ----------------------------------------------------------------------------
// cordic_sine_cosine_top
// Rotation-mode CORDIC sine/cosine generator, one angle per clock.
// ----------------------------------------------------------------------------
//  Channel   Ports                               Direction  Handshake
//  angle     start, busy, angle_i                in         start & !busy
//  result    done_o, cosine_o, sine_o            out        done_o strobe
//  config    cfg_we_i, cfg_wdata_i               in         cfg_we_i
//
//  Each micro-rotation cell registers its result, then the gain multiply and
//  the saturation into the output register are registered in turn.
//  Throughput is one angle per clock; busy stays low, since the cell row
//  advances every cycle and each result leaves on its own strobe.
//  Reset clears the valid bits of the row and loads an iteration count of 16.
//  The receiver cannot stall; every result is a one-cycle done_o transfer.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_top #(
  parameter int MAX_ITERATIONS = cscos_pkg::DEF_MAX_ITER,
  parameter int FRACTION_BITS  = cscos_pkg::DEF_FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [cscos_pkg::FIELD_W-1:0]  angle_i,
  input  logic                                  cfg_we_i,
  input  logic [cscos_pkg::CNT_W-1:0]           cfg_wdata_i,
  output logic                                  done_o,
  output logic signed [cscos_pkg::FIELD_W-1:0]  cosine_o,
  output logic signed [cscos_pkg::FIELD_W-1:0]  sine_o
);
  import cscos_pkg::*;

  // |x|,|y| stay below about 1.65 * 2^FRACTION_BITS; keep headroom.
  localparam int DW = FRACTION_BITS + 3;
  // |z| never grows beyond the larger of the input angle and atan(1).
  localparam int ZW = ((FRACTION_BITS + 2 > FIELD_W) ? FRACTION_BITS + 2 : FIELD_W) + 1;

  logic [CNT_W-1:0]     iter_q;
  cell_ctrl_t           ctrl [MAX_ITERATIONS+1];
  logic signed [DW-1:0] xv   [MAX_ITERATIONS+1];
  logic signed [DW-1:0] yv   [MAX_ITERATIONS+1];
  logic signed [ZW-1:0] zv   [MAX_ITERATIONS+1];

  // Hold the iteration count; the user must write it only while the row is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= ITER_RESET;
    end else if (cfg_we_i) begin
      iter_q <= cfg_wdata_i;
    end
  end

  // The row never blocks: a new angle may enter on every clock.
  assign busy = 1'b0;

  // Seed the first cell with the vector (1, 0) and the incoming angle.
  assign ctrl[0].valid = start;
  assign ctrl[0].count = iter_q;
  assign xv[0]         = DW'(1) <<< FRACTION_BITS;
  assign yv[0]         = '0;
  assign zv[0]         = ZW'(angle_i);

  // One cell per micro-rotation; a cell past the item's count passes through.
  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_cell
    cscos_cell #(
      .STAGE     (g),
      .FRAC_BITS (FRACTION_BITS),
      .DW        (DW),
      .ZW        (ZW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[g]),
      .x_i    (xv[g]),
      .y_i    (yv[g]),
      .z_i    (zv[g]),
      .ctrl_o (ctrl[g+1]),
      .x_o    (xv[g+1]),
      .y_o    (yv[g+1]),
      .z_o    (zv[g+1])
    );
  end

  // Scale by K and saturate into the result register.
  cscos_gain #(
    .DW (DW)
  ) u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ctrl[MAX_ITERATIONS].valid),
    .x_i     (xv[MAX_ITERATIONS]),
    .y_i     (yv[MAX_ITERATIONS]),
    .valid_o (done_o),
    .x_o     (cosine_o),
    .y_o     (sine_o)
  );

endmodule
